[rtl/rcdb_pkg.sv]
// shared types and constants of the direct-bit range encoder
package rcdb_pkg;

    localparam int DATA_W          = 32;
    localparam int COUNT_W         = 6;
    localparam int LOW_W           = 33;
    localparam int RANGE_W         = 32;
    localparam int BYTE_W          = 8;
    localparam int FILL_W          = 32;
    localparam int MAX_DIRECT_BITS = 32;
    localparam int IDX_W           = $clog2(MAX_DIRECT_BITS);

    localparam logic [RANGE_W-1:0] TOP_LIMIT  = 32'h0100_0000;
    localparam logic [RANGE_W-1:0] RANGE_INIT = 32'hFFFF_FFFF;
    localparam logic [FILL_W-1:0]  FILL_MAX   = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0]  BYTE_ONES  = 8'hFF;

    localparam logic [1:0] REQ_BITS  = 2'd0;
    localparam logic [1:0] REQ_SHIFT = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIT,
        ST_SHIFT,
        ST_END
    } rcdb_state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic bit_step;
        logic shift_step;
        logic flush_hold;
    } rcdb_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_last;
        logic norm_needed;
        logic byte_release;
        logic hold_valid;
        logic out_free;
    } rcdb_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] lead_byte;
        logic [BYTE_W-1:0] fill_byte;
        logic [FILL_W-1:0] fill_count;
        logic              last;
    } rcdb_res_t;

endpackage

[rtl/rcdb_req_if.sv]
// request and result channel interfaces
interface rcdb_req_if import rcdb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [DATA_W-1:0]  bits_value;
    logic [COUNT_W-1:0] bits_used;

    modport source (output valid, output req_type, output bits_value, output bits_used,
                    input ready);
    modport sink (input valid, input req_type, input bits_value, input bits_used,
                  output ready);
endinterface

interface rcdb_res_if import rcdb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] lead_byte;
    logic [BYTE_W-1:0] fill_byte;
    logic [FILL_W-1:0] fill_count;
    logic              last;

    modport source (output valid, output lead_byte, output fill_byte, output fill_count,
                    output last, input ready);
    modport sink (input valid, input lead_byte, input fill_byte, input fill_count,
                  input last, output ready);
endinterface

[rtl/rcdb_datapath.sv]
// coder state, bit step, low shift, held result and output register
module rcdb_datapath import rcdb_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  rcdb_cmd_t          cmd,
    output rcdb_status_t       status,
    input  logic [DATA_W-1:0]  bits_value,
    input  logic [COUNT_W-1:0] bits_used,
    rcdb_res_if.source         res
);

    logic [LOW_W-1:0]   low_reg, low_next;
    logic [RANGE_W-1:0] range_reg, range_next;
    logic [BYTE_W-1:0]  cached_reg, cached_next;
    logic [FILL_W-1:0]  pending_reg, pending_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               hold_valid_reg, hold_valid_next;
    logic               out_valid_reg, out_valid_next;
    rcdb_res_t          hold_reg, hold_next;
    rcdb_res_t          out_reg, out_next;

    logic [RANGE_W-1:0] half;
    logic [LOW_W-1:0]   low_sum;
    logic [COUNT_W-1:0] count_dec;
    logic [IDX_W-1:0]   bit_idx;
    logic               cur_bit;
    logic               norm;
    logic               byte_release;
    logic               carry;
    logic               out_free;
    rcdb_res_t          new_res;

    assign half         = range_reg >> 1;
    assign low_sum      = low_reg + {1'b0, half};
    assign count_dec    = count_reg - COUNT_W'(1);
    assign bit_idx      = count_dec[IDX_W-1:0];
    assign cur_bit      = value_reg[bit_idx];
    assign norm         = half < TOP_LIMIT;
    assign carry        = low_reg[LOW_W-1];
    // a byte leaves unless it may still be hit by a carry (top byte all ones)
    assign byte_release = carry || (low_reg[RANGE_W-1 -: BYTE_W] != BYTE_ONES);
    assign out_free     = !out_valid_reg || res.ready;

    assign new_res.lead_byte  = cached_reg + {{(BYTE_W-1){1'b0}}, carry};
    assign new_res.fill_byte  = BYTE_ONES + {{(BYTE_W-1){1'b0}}, carry};
    assign new_res.fill_count = pending_reg;
    assign new_res.last       = 1'b0;

    assign status.count_zero   = count_reg == '0;
    assign status.count_last   = count_reg == COUNT_W'(1);
    assign status.norm_needed  = norm;
    assign status.byte_release = byte_release;
    assign status.hold_valid   = hold_valid_reg;
    assign status.out_free     = out_free;

    always_comb
    begin
        low_next        = low_reg;
        range_next      = range_reg;
        cached_next     = cached_reg;
        pending_next    = pending_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res.ready;

        if (cmd.clear)
        begin
            low_next     = '0;
            range_next   = RANGE_INIT;
            cached_next  = '0;
            pending_next = '0;
        end

        if (cmd.load)
        begin
            value_next = bits_value;
            if (bits_used > COUNT_W'(MAX_DIRECT_BITS))
                count_next = COUNT_W'(MAX_DIRECT_BITS);
            else
                count_next = bits_used;
        end

        if (cmd.bit_step)
        begin
            count_next = count_dec;
            if (cur_bit)
                low_next = low_sum;
            if (norm)
                range_next = {half[RANGE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            else
                range_next = half;
        end

        if (cmd.shift_step)
        begin
            low_next = {1'b0, low_reg[RANGE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            if (byte_release)
            begin
                cached_next     = low_reg[RANGE_W-1 -: BYTE_W];
                pending_next    = '0;
                hold_next       = new_res;
                hold_valid_next = 1'b1;
                // the earlier group is not the final one of this request
                if (hold_valid_reg)
                begin
                    out_next       = hold_reg;
                    out_next.last  = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            else if (pending_reg != FILL_MAX)
            begin
                pending_next = pending_reg + FILL_W'(1);
            end
        end

        if (cmd.flush_hold)
        begin
            out_next        = hold_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg        <= '0;
            range_reg      <= RANGE_INIT;
            cached_reg     <= '0;
            pending_reg    <= '0;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            low_reg        <= low_next;
            range_reg      <= range_next;
            cached_reg     <= cached_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hold_reg  <= hold_next;
        out_reg   <= out_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.lead_byte  = out_reg.lead_byte;
    assign res.fill_byte  = out_reg.fill_byte;
    assign res.fill_count = out_reg.fill_count;
    assign res.last       = out_reg.last;

    a_range_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        range_reg >= TOP_LIMIT)
        else $error("range fell below the renormalization limit");

    a_flush_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_hold |-> hold_valid_reg && out_free)
        else $error("held result flushed without room or content");

    a_release_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_step && byte_release && hold_valid_reg |-> out_free)
        else $error("held result overwritten while output is busy");

    a_shift_clears_carry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_step && !cmd.clear |=> !low_reg[LOW_W-1])
        else $error("carry bit survived a low shift");

endmodule

[rtl/rcdb_ctrl.sv]
// sequencing state machine of the direct-bit range encoder
module rcdb_ctrl import rcdb_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic [1:0]   req_type,
    input  logic         bits_zero,
    output logic         req_ready,
    input  rcdb_status_t status,
    output rcdb_cmd_t    cmd
);

    rcdb_state_t state_reg, state_next;
    logic        shift_stall;

    // a released byte group must push the held one out first
    assign shift_stall = status.byte_release && status.hold_valid && !status.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_type)
                        REQ_BITS:  state_next = bits_zero ? ST_IDLE : ST_BIT;
                        REQ_SHIFT: state_next = ST_SHIFT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BIT:
            begin
                if (status.norm_needed)
                    state_next = ST_SHIFT;
                else if (status.count_last)
                    state_next = ST_END;
                else
                    state_next = ST_BIT;
            end
            ST_SHIFT:
            begin
                if (shift_stall)
                    state_next = ST_SHIFT;
                else if (status.count_zero)
                    state_next = ST_END;
                else
                    state_next = ST_BIT;
            end
            ST_END:
            begin
                if (!status.hold_valid || status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid && (req_type == REQ_BITS) && !bits_zero;
                cmd.clear = req_valid && (req_type == REQ_RESET);
            end
            ST_BIT:   cmd.bit_step   = 1'b1;
            ST_SHIFT: cmd.shift_step = !shift_stall;
            ST_END:   cmd.flush_hold = status.hold_valid && status.out_free;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/range_coder_direct_bits.sv]
// direct-bit range encoder: request channel in, byte-group result channel out
//
// requests arrive on req (valid/ready). req_type selects: encode bits_used
// direct bits of bits_value msb first, shift low once (flush), or reset the
// coder. results leave on res as a lead byte plus a run of fill_count fill
// bytes; last marks the final group a request caused. requests that release
// no byte give no result.
// a request is taken only while the sequencer is idle. an encode request steps
// through its bits one at a time in the halving adder, does one low byte
// shift per renormalization it hits, and then closes out the held group; a
// shift request does one low byte shift and closes out, a reset request
// only clears the coder state.
// each released group is held until last can be decided; when the
// receiver stalls, the output register keeps its group and the sequencer
// waits only when it must push another group into that register.
// reset puts low and the cached byte to zero, range to all ones, clears the
// pending count and empties the held and output groups.
module range_coder_direct_bits import rcdb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    rcdb_req_if.sink   req,
    rcdb_res_if.source res
);

    rcdb_cmd_t    cmd;
    rcdb_status_t status;

    rcdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .bits_zero (req.bits_used == '0),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rcdb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .bits_value (req.bits_value),
        .bits_used  (req.bits_used),
        .res        (res)
    );

endmodule
